@@ sv/light_schedule_matcher_defines.svh @@
// Assertion macros shared by the light schedule matcher RTL.
`ifndef LIGHT_SCHEDULE_MATCHER_DEFINES_SVH
`define LIGHT_SCHEDULE_MATCHER_DEFINES_SVH

// Generic clocked assertion with an active-low reset that disables the check.
`define LSM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on the standard clock and reset port names.
`define LSM_ASSERT_STD(label, prop, msg) \
  `LSM_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

@@ sv/lsm_pkg.sv @@
// Types and constants of the light schedule matcher.
package lsm_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [16:0] SEC_PER_DAY = 17'd86400;
  localparam logic [2:0] WORKDAY_FIRST = 3'd1;
  localparam logic [2:0] WORKDAY_LAST = 3'd5;
  localparam logic [2:0] WEEKEND_FIRST = 3'd6;
  localparam logic [2:0] WEEKEND_LAST = 3'd7;

  typedef enum logic [1:0] {
    ENT_WORKDAY = 2'd0,
    ENT_RESTDAY = 2'd1,
    ENT_DATED   = 2'd2,
    ENT_NONE    = 2'd3
  } ent_type_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SKIP  = 2'd1,
    OP_EVAL  = 2'd2
  } op_e;

  localparam logic CMD_WRITE = 1'b0;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  slot;
    logic [2:0]  kind;
    logic [16:0] seconds_from;
    logic [16:0] seconds_to;
    logic [6:0]  entry_level;
    logic [6:0]  year_from;
    logic [6:0]  year_to;
    logic [3:0]  month_from;
    logic [3:0]  month_to;
    logic [4:0]  day_from;
    logic [4:0]  day_to;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic [2:0] match_slot;
    logic [7:0] light_level;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e       op;
    ent_type_e etype;
    in_item_t  item;
  } cmd_t;

  // Time window part of one schedule entry.
  typedef struct packed {
    logic [16:0] start;
    logic [16:0] stop;
    logic [6:0]  level;
  } window_t;

  // Date range part of one schedule entry.
  typedef struct packed {
    logic [6:0] y_lo;
    logic [6:0] y_hi;
    logic [3:0] m_lo;
    logic [3:0] m_hi;
    logic [4:0] d_lo;
    logic [4:0] d_hi;
  } date_t;

  // Queue status and data seen by the back end.
  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } queue_head_t;

endpackage

@@ sv/lsm_front.sv @@
// Front end: accepts transactions, classifies them and queues them for the back end.
module lsm_front import lsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  input  logic        q_pop_i,
  output queue_head_t q_head_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;
  cmd_t             cmd_new;

  // Sort the transaction: out-of-range slots become no-ops, unknown types become none.
  always_comb begin
    cmd_new.item = in_item_i;
    if (in_item_i.kind <= 3'(ENT_NONE)) begin
      cmd_new.etype = ent_type_e'(in_item_i.kind[1:0]);
    end else begin
      cmd_new.etype = ENT_NONE;
    end
    if (in_item_i.cmd != CMD_WRITE) begin
      cmd_new.op = OP_EVAL;
    end else if (7'(in_item_i.slot) < 7'(ENTRIES)) begin
      cmd_new.op = OP_WRITE;
    end else begin
      cmd_new.op = OP_SKIP;
    end
  end

  assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = q_pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign q_head_o.empty = (cnt_q == '0);
  assign q_head_o.cmd   = mem_q[rd_ptr_q];

endmodule

@@ sv/lsm_back.sv @@
// Back end: schedule tables, entry scan, light level and result register.
`include "light_schedule_matcher_defines.svh"

module lsm_back import lsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t q_head_i,
  output logic        q_pop_o,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  ent_type_e        type_q [ENTRIES];
  window_t          win_q  [ENTRIES];
  date_t            date_q [ENTRIES];

  logic             state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  in_item_t         ev_q;
  logic [7:0]       level_q, level_d;
  logic             res_valid_q, res_valid_d;
  out_item_t        res_q, res_d;
  logic             res_load, tbl_we, ev_load, out_free;
  logic             day_ok, win_ok, hit, last;
  window_t          win_cur;
  date_t            date_cur;
  logic [16:0]      now;

  assign win_cur  = win_q[idx_q];
  assign date_cur = date_q[idx_q];
  assign now      = ev_q.seconds_from;

  // Day check of the entry under the scan index.
  always_comb begin
    case (type_q[idx_q])
      ENT_WORKDAY: day_ok = (ev_q.kind >= WORKDAY_FIRST) && (ev_q.kind <= WORKDAY_LAST);
      ENT_RESTDAY: day_ok = (ev_q.kind >= WEEKEND_FIRST) && (ev_q.kind <= WEEKEND_LAST);
      ENT_DATED:   day_ok = (date_cur.y_lo <= ev_q.year_from) &&
                            (ev_q.year_from <= date_cur.y_hi) &&
                            (date_cur.m_lo <= ev_q.month_from) &&
                            (ev_q.month_from <= date_cur.m_hi) &&
                            (date_cur.d_lo <= ev_q.day_from) &&
                            (ev_q.day_from <= date_cur.d_hi);
      default:     day_ok = 1'b0;
    endcase
  end

  // Time window check; a window whose start lies after its end wraps past midnight.
  always_comb begin
    if (win_cur.start > win_cur.stop) begin
      win_ok = ((win_cur.start <= now) && (now <= SEC_PER_DAY)) || (now <= win_cur.stop);
    end else if (win_cur.start < win_cur.stop) begin
      win_ok = (win_cur.start <= now) && (now <= win_cur.stop);
    end else begin
      win_ok = 1'b0;
    end
  end

  assign hit      = day_ok && win_ok;
  assign last     = (idx_q == IDX_LAST);
  assign out_free = !res_valid_q || pop;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    level_d  = level_q;
    q_pop_o  = 1'b0;
    res_load = 1'b0;
    tbl_we   = 1'b0;
    ev_load  = 1'b0;
    res_d    = '0;
    res_d.light_level = level_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_head_i.empty) begin
          if (q_head_i.cmd.op == OP_EVAL) begin
            q_pop_o = 1'b1;
            ev_load = 1'b1;
            idx_d   = '0;
            state_d = ST_SCAN;
          end else if (out_free) begin
            q_pop_o  = 1'b1;
            res_load = 1'b1;
            tbl_we   = (q_head_i.cmd.op == OP_WRITE);
          end
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          if (out_free) begin
            res_load = 1'b1;
            state_d  = ST_IDLE;
            if (hit) begin
              level_d           = {win_cur.level, 1'b0};
              res_d.matched     = 1'b1;
              res_d.match_slot  = 3'(idx_q);
              res_d.light_level = {win_cur.level, 1'b0};
            end
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_d = res_load || (res_valid_q && !pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      level_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      level_q     <= level_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Entry types reset to none so that unwritten entries never match.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        type_q[i] <= ENT_NONE;
      end
    end else if (tbl_we) begin
      type_q[IDX_W'(q_head_i.cmd.item.slot)] <= q_head_i.cmd.etype;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      win_q[IDX_W'(q_head_i.cmd.item.slot)] <= '{
        start: q_head_i.cmd.item.seconds_from,
        stop:  q_head_i.cmd.item.seconds_to,
        level: q_head_i.cmd.item.entry_level
      };
      date_q[IDX_W'(q_head_i.cmd.item.slot)] <= '{
        y_lo: q_head_i.cmd.item.year_from,
        y_hi: q_head_i.cmd.item.year_to,
        m_lo: q_head_i.cmd.item.month_from,
        m_hi: q_head_i.cmd.item.month_to,
        d_lo: q_head_i.cmd.item.day_from,
        d_hi: q_head_i.cmd.item.day_to
      };
    end
    if (ev_load) begin
      ev_q <= q_head_i.cmd.item;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign empty      = !res_valid_q;
  assign out_item_o = res_q;

  `LSM_ASSERT_STD(a_load_only_when_free, res_load |-> (!res_valid_q || pop), "result overwritten")
  `LSM_ASSERT_STD(a_pop_only_idle, q_pop_o |-> (state_q == ST_IDLE), "queue popped while busy")
  `LSM_ASSERT_STD(a_level_kept_on_miss, (res_load && !res_d.matched) |=> $stable(level_q), "level changed without a match")
  `LSM_ASSERT_STD(a_scan_ends_in_idle, (state_q == ST_SCAN && last && out_free) |=> (state_q == ST_IDLE), "scan ran past the last entry")

endmodule

@@ sv/light_schedule_matcher.sv @@
// Top level of the light schedule matcher: front queue and back-end scanner.

// The light schedule matcher keeps eight schedule entries and the current light level.
// Both sides look like queues: a transaction is taken when push is high and full is low,
// and a result is taken when pop is high and empty is low; every input transaction
// returns exactly one result, in order. A write transaction stores one entry (type,
// time window, level and date ranges) and returns matched 0 with the level unchanged;
// writes to a slot beyond the table and unknown types are harmless. An evaluate
// transaction scans the entries in index order and the first one whose day rule and
// time window both match sets the level to twice its entry level. A front queue of two
// transactions decouples input from the back end, so up to two transactions can be
// waiting while a scan runs and while a result waits to be popped. The back end takes
// one transaction at a time from the head of the queue, and only while it is idle; a
// write also waits until the result register is free, and its result is registered as
// it is taken. An evaluate is first loaded and then steps over the entries in index
// order, up to all eight when nothing matches, because a single set of window and date
// comparators is stepped over the table; a result left waiting on the output stalls
// the back end. After reset all entries have type none and the level is zero.
module light_schedule_matcher import lsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  queue_head_t q_head;
  logic        q_pop;

  // Front end: classifies each transaction and holds it until the back end is free.
  lsm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_pop_i   (q_pop),
    .q_head_o  (q_head)
  );

  // Back end: owns the tables and the level, scans entries and registers the result.
  lsm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule
